// ----- design/swdm_pkg.sv -----
// Shared types, constants and the sine table for the sliding-window DFT magnitude unit.
package swdm_pkg;

  localparam int WINDOW_SIZE_DEF = 64;
  localparam int NUM_BINS_DEF    = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam int SAMPLE_W  = 16;
  localparam int HOP_W     = 7;
  localparam int BIN_W     = 5;
  localparam int MAG_W     = 22;
  localparam int PHASE_W   = 7;
  localparam int SINE_W    = 16;
  localparam int ROUND_SH  = 14;

  localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;
  localparam logic [MAG_W-1:0] MAG_MAX   = 22'd4194303;

  // round(16384*sin(i*pi/64)), i = 0..32
  localparam logic [14:0] QUARTER_SINE [33] = '{
    15'd0,     15'd804,   15'd1606,  15'd2404,  15'd3196,  15'd3981,  15'd4756,  15'd5520,
    15'd6270,  15'd7005,  15'd7723,  15'd8423,  15'd9102,  15'd9760,  15'd10394, 15'd11003,
    15'd11585, 15'd12140, 15'd12665, 15'd13160, 15'd13623, 15'd14053, 15'd14449, 15'd14811,
    15'd15137, 15'd15426, 15'd15679, 15'd15893, 15'd16069, 15'd16207, 15'd16305, 15'd16364,
    15'd16384
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } back_state_e;

  // Q14 sine on a 128-step circle.
  function automatic logic signed [SINE_W-1:0] sine_q14(input logic [PHASE_W-1:0] p);
    logic [1:0]  q;
    logic [5:0]  r;
    logic [14:0] mag;
    q = p[6:5];
    r = {1'b0, p[4:0]};
    if (q[0]) begin
      mag = QUARTER_SINE[6'd32 - r];
    end else begin
      mag = QUARTER_SINE[r];
    end
    if (q[1]) begin
      sine_q14 = -$signed({1'b0, mag});
    end else begin
      sine_q14 = $signed({1'b0, mag});
    end
  endfunction

endpackage

// ----- design/sliding_window_dft_magnitude_unit.sv -----
// Top level of the sliding-window DFT magnitude unit (one channel).
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_ready_o   sample_i (16b signed)
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i = hop_length (7b)
//   out      out  out_valid_o/out_ready_i bin_index_o, magnitude_o, last_bin_o
//
// A word that does not close a hop only updates the window and hop count. A
// word that closes a hop starts a spectrum: the job is popped, then per bin a
// serial MAC runs through the single window read port, followed by drain,
// round/square/sum, RW root steps (26 at default) and the output.
// The input is held off while a spectrum job is queued or running; cfg is
// always ready. Reset is asynchronous active low; window slots not yet
// written read as zero via per-slot valid bits, so no clearing pass.
// A stalled output holds the engine in its output state only.
module sliding_window_dft_magnitude_unit #(
  parameter int WINDOW_SIZE = swdm_pkg::WINDOW_SIZE_DEF,
  parameter int NUM_BINS    = swdm_pkg::NUM_BINS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [swdm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swdm_pkg::HOP_W-1:0]           cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [swdm_pkg::BIN_W-1:0]           bin_index_o,
  output logic [swdm_pkg::MAG_W-1:0]           magnitude_o,
  output logic                                 last_bin_o
);

  localparam int AW = $clog2(WINDOW_SIZE);

  logic                                 job_push, job_pop, job_empty, job_full, busy;
  logic [AW-1:0]                        job_start_in, job_start_out, rd_addr;
  logic signed [swdm_pkg::SAMPLE_W-1:0] rd_data;
  logic                                 stall;

  // window must not change while a job waits or runs
  assign stall = !job_empty || busy || job_full;

  swdm_front #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .AW         (AW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .stall_i    (stall),
    .job_push_o (job_push),
    .job_start_o(job_start_in),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  swdm_queue #(
    .DATA_W(AW),
    .DEPTH (swdm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_start_in),
    .pop_i      (job_pop),
    .pop_data_o (job_start_out),
    .empty_o    (job_empty),
    .full_o     (job_full)
  );

  swdm_back #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .NUM_BINS   (NUM_BINS),
    .AW         (AW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_start_i(job_start_out),
    .job_pop_o  (job_pop),
    .busy_o     (busy),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .bin_index_o(bin_index_o),
    .magnitude_o(magnitude_o),
    .last_bin_o (last_bin_o)
  );

endmodule

// ----- design/swdm_queue.sv -----
// Small job FIFO between the sample front end and the spectrum engine.
module swdm_queue #(
  parameter int DATA_W = 6,
  parameter int DEPTH  = swdm_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == CW'(DEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/swdm_front.sv -----
// Front end: accepts sample words, keeps the window ring and hop count, issues spectrum jobs.
module swdm_front #(
  parameter int WINDOW_SIZE = swdm_pkg::WINDOW_SIZE_DEF,
  parameter int AW          = $clog2(WINDOW_SIZE)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swdm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swdm_pkg::HOP_W-1:0]          cfg_data_i,
  input  logic                                stall_i,
  output logic                                job_push_o,
  output logic [AW-1:0]                       job_start_o,
  input  logic [AW-1:0]                       rd_addr_i,
  output logic signed [swdm_pkg::SAMPLE_W-1:0] rd_data_o
);

  logic signed [swdm_pkg::SAMPLE_W-1:0] mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]               vld_q;
  logic signed [swdm_pkg::SAMPLE_W-1:0] rd_data_q;
  logic                                 rd_vld_q;
  logic [AW-1:0]                        wp_q, wp_d;
  logic [swdm_pkg::HOP_W-1:0]           hop_cnt_q, hop_cnt_d, hop_inc;
  logic [swdm_pkg::HOP_W-1:0]           hop_len_q;
  logic                                 accept;

  assign in_ready_o  = !stall_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  assign hop_inc     = hop_cnt_q + 1'b1;
  assign wp_d        = (wp_q == AW'(WINDOW_SIZE - 1)) ? '0 : wp_q + 1'b1;
  assign job_push_o  = accept && (hop_inc >= hop_len_q);
  assign job_start_o = wp_d;
  assign hop_cnt_d   = job_push_o ? '0 : hop_inc;

  // slots never written read as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      hop_cnt_q <= '0;
      hop_len_q <= swdm_pkg::HOP_RESET;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr_i];
      if (cfg_valid_i && cfg_ready_o) begin
        hop_len_q <= cfg_data_i;
      end
      if (accept) begin
        wp_q        <= wp_d;
        hop_cnt_q   <= hop_cnt_d;
        vld_q[wp_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wp_q] <= sample_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

endmodule

// ----- design/swdm_back.sv -----
// Spectrum engine: serial DFT MAC per bin, rounding, squares, bit-serial root, result register.
module swdm_back #(
  parameter int WINDOW_SIZE = swdm_pkg::WINDOW_SIZE_DEF,
  parameter int NUM_BINS    = swdm_pkg::NUM_BINS_DEF,
  parameter int AW          = $clog2(WINDOW_SIZE)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_empty_i,
  input  logic [AW-1:0]                       job_start_i,
  output logic                                job_pop_o,
  output logic                                busy_o,
  output logic [AW-1:0]                       rd_addr_o,
  input  logic signed [swdm_pkg::SAMPLE_W-1:0] rd_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [swdm_pkg::BIN_W-1:0]          bin_index_o,
  output logic [swdm_pkg::MAG_W-1:0]          magnitude_o,
  output logic                                last_bin_o
);

  localparam int KW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int PROD_W = 2 * swdm_pkg::SINE_W;
  localparam int ACC_W  = PROD_W + AW;
  localparam int A_W    = ACC_W + 1 - swdm_pkg::ROUND_SH;
  localparam int SQ_W   = 2 * A_W;
  localparam int RW     = (SQ_W + 2) / 2;
  localparam int SW     = $clog2(RW + 1);

  // phase on the 128-step circle for each m = (t*k) mod W
  logic [swdm_pkg::PHASE_W-1:0] phase_lut [WINDOW_SIZE];
  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_phase
    localparam int PH = ((i * 128 + WINDOW_SIZE / 2) / WINDOW_SIZE) % 128;
    assign phase_lut[i] = swdm_pkg::PHASE_W'(PH);
  end

  swdm_pkg::back_state_e state_q, state_d;

  logic [AW-1:0]  addr_q, t_q, m_q, kmod_q, start_q;
  logic [KW-1:0]  k_q;
  logic           v1_q, v2_q, v3_q;
  logic [swdm_pkg::PHASE_W-1:0]        ph_q;
  logic signed [swdm_pkg::SAMPLE_W-1:0] x_q;
  logic signed [swdm_pkg::SINE_W-1:0]   cos_q, sin_q;
  logic signed [PROD_W-1:0]             pre_q, pim_q;
  logic signed [ACC_W-1:0]              re_q, im_q;
  logic [ACC_W-1:0]                     abs_re, abs_im;
  logic [A_W-1:0]                       a_q, b_q;
  logic [SQ_W-1:0]                      sqa_q, sqb_q;
  logic [2*RW-1:0]                      v_q;
  logic [RW+1:0]                        rem_q, rem_sh, trial;
  logic [RW-1:0]                        root_q;
  logic [SW-1:0]                        step_q;
  logic                                 out_load, mac_last, root_last, bin_last;
  logic [AW:0]                          m_sum;

  assign mac_last  = (t_q == AW'(WINDOW_SIZE - 1));
  assign root_last = (step_q == SW'(RW - 1));
  assign bin_last  = (k_q == KW'(NUM_BINS - 1));
  assign rd_addr_o = addr_q;
  assign m_sum     = {1'b0, m_q} + {1'b0, kmod_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      swdm_pkg::ST_IDLE:   if (!job_empty_i) state_d = swdm_pkg::ST_MAC;
      swdm_pkg::ST_MAC:    if (mac_last) state_d = swdm_pkg::ST_DRAIN;
      swdm_pkg::ST_DRAIN:  if (!v1_q && !v2_q && !v3_q) state_d = swdm_pkg::ST_ROUND;
      swdm_pkg::ST_ROUND:  state_d = swdm_pkg::ST_SQUARE;
      swdm_pkg::ST_SQUARE: state_d = swdm_pkg::ST_SUM;
      swdm_pkg::ST_SUM:    state_d = swdm_pkg::ST_ROOT;
      swdm_pkg::ST_ROOT:   if (root_last) state_d = swdm_pkg::ST_OUT;
      swdm_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = bin_last ? swdm_pkg::ST_IDLE : swdm_pkg::ST_MAC;
        end
      end
      default: state_d = swdm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = (state_q == swdm_pkg::ST_IDLE) && !job_empty_i;
    busy_o    = (state_q != swdm_pkg::ST_IDLE);
    out_load  = (state_q == swdm_pkg::ST_OUT) && (!out_valid_o || out_ready_i);
  end

  assign abs_re = re_q[ACC_W-1] ? ACC_W'(-re_q) : ACC_W'(re_q);
  assign abs_im = im_q[ACC_W-1] ? ACC_W'(-im_q) : ACC_W'(im_q);
  assign rem_sh = {rem_q[RW-1:0], v_q[2*RW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swdm_pkg::ST_IDLE;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      k_q         <= '0;
      kmod_q      <= '0;
      t_q         <= '0;
      m_q         <= '0;
      addr_q      <= '0;
      start_q     <= '0;
      step_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == swdm_pkg::ST_MAC);
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (job_pop_o) begin
        start_q <= job_start_i;
        addr_q  <= job_start_i;
        k_q     <= '0;
        kmod_q  <= '0;
        t_q     <= '0;
        m_q     <= '0;
      end
      if (state_q == swdm_pkg::ST_MAC) begin
        t_q    <= mac_last ? '0 : t_q + 1'b1;
        m_q    <= (m_sum >= (AW+1)'(WINDOW_SIZE)) ? AW'(m_sum - (AW+1)'(WINDOW_SIZE))
                                                  : AW'(m_sum);
        addr_q <= (addr_q == AW'(WINDOW_SIZE - 1)) ? '0 : addr_q + 1'b1;
      end
      if (state_q == swdm_pkg::ST_DRAIN) begin
        m_q    <= '0;
        addr_q <= start_q;
      end
      if (state_q == swdm_pkg::ST_SUM) begin
        step_q <= '0;
      end else if (state_q == swdm_pkg::ST_ROOT) begin
        step_q <= step_q + 1'b1;
      end
      if (out_load) begin
        k_q    <= k_q + 1'b1;
        kmod_q <= (kmod_q == AW'(WINDOW_SIZE - 1)) ? '0 : kmod_q + 1'b1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= phase_lut[m_q];
    x_q   <= rd_data_i;
    cos_q <= swdm_pkg::sine_q14(ph_q + 7'd32);
    sin_q <= swdm_pkg::sine_q14(ph_q);
    pre_q <= x_q * cos_q;
    pim_q <= x_q * sin_q;
    if (state_q == swdm_pkg::ST_IDLE || state_q == swdm_pkg::ST_OUT) begin
      re_q <= '0;
      im_q <= '0;
    end else if (v3_q) begin
      re_q <= re_q + ACC_W'(pre_q);
      im_q <= im_q - ACC_W'(pim_q);
    end
    if (state_q == swdm_pkg::ST_ROUND) begin
      a_q <= A_W'(({1'b0, abs_re} + (ACC_W+1)'(8192)) >> swdm_pkg::ROUND_SH);
      b_q <= A_W'(({1'b0, abs_im} + (ACC_W+1)'(8192)) >> swdm_pkg::ROUND_SH);
    end
    if (state_q == swdm_pkg::ST_SQUARE) begin
      sqa_q <= a_q * a_q;
      sqb_q <= b_q * b_q;
    end
    if (state_q == swdm_pkg::ST_SUM) begin
      v_q    <= (2*RW)'(sqa_q) + (2*RW)'(sqb_q);
      rem_q  <= '0;
      root_q <= '0;
    end else if (state_q == swdm_pkg::ST_ROOT) begin
      v_q <= {v_q[2*RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (out_load) begin
      bin_index_o <= swdm_pkg::BIN_W'(k_q);
      last_bin_o  <= bin_last;
      magnitude_o <= (root_q > RW'(swdm_pkg::MAG_MAX)) ? swdm_pkg::MAG_MAX
                                                      : swdm_pkg::MAG_W'(root_q);
    end
  end

  a_mac_pipe_only_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (state_q == swdm_pkg::ST_MAC || state_q == swdm_pkg::ST_DRAIN))
    else $error("MAC pipeline active outside MAC/drain");

  a_last_bin_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && bin_last) |=> (state_q == swdm_pkg::ST_IDLE && last_bin_o))
    else $error("last bin did not end the spectrum run");

  a_root_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swdm_pkg::ST_ROOT) |-> (step_q < SW'(RW)))
    else $error("square root step count overrun");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sliding-window DFT magnitude unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN  = swdm_pkg::WINDOW_SIZE_DEF;
  localparam int BINS = swdm_pkg::NUM_BINS_DEF;
  localparam int SPECTRUM_CYCLES = BINS * (WIN + 40);
  localparam longint CYCLE_LIMIT = 64'd4000000;

  typedef struct packed {
    logic [swdm_pkg::BIN_W-1:0] bin_index;
    logic [swdm_pkg::MAG_W-1:0] magnitude;
    logic                       last_bin;
  } bin_word_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  // DUT ports
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic signed [swdm_pkg::SAMPLE_W-1:0] sample_i = '0;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [swdm_pkg::HOP_W-1:0]           cfg_data_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [swdm_pkg::BIN_W-1:0]           bin_index_o;
  logic [swdm_pkg::MAG_W-1:0]           magnitude_o;
  logic                                 last_bin_o;

  sliding_window_dft_magnitude_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .bin_index_o(bin_index_o),
    .magnitude_o(magnitude_o),
    .last_bin_o (last_bin_o)
  );

  // Predictor state: its own copy of the window ring, hop counter and setting.
  logic signed [swdm_pkg::SAMPLE_W-1:0] ring [WIN];
  int unsigned ring_wr;
  int unsigned hop_seen;
  int unsigned hop_len;

  bin_word_t   expected_bins[$];
  logic signed [swdm_pkg::SAMPLE_W-1:0] pending_samples[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  bit          driver_paused = 1'b0;
  bit          hold_off_req = 1'b0;
  int          hold_off_left = 0;

  function automatic longint quarter_sine_q14(int unsigned p);
    int unsigned q;
    int unsigned r;
    q = (p >> 5) & 3;
    r = p & 31;
    case (q)
      0: return longint'(swdm_pkg::QUARTER_SINE[r]);
      1: return longint'(swdm_pkg::QUARTER_SINE[32 - r]);
      2: return -longint'(swdm_pkg::QUARTER_SINE[r]);
      default: return -longint'(swdm_pkg::QUARTER_SINE[32 - r]);
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned round_mag_q14(longint v);
    longint unsigned a;
    a = (v < 0) ? longint'(-v) : v;
    return (a + 8192) >> 14;
  endfunction

  // Window the new sample in; on a closed hop queue the whole bin run.
  task automatic predict_spectrum(logic signed [swdm_pkg::SAMPLE_W-1:0] s);
    longint re;
    longint im;
    longint x;
    longint unsigned a;
    longint unsigned b;
    longint unsigned mag;
    int unsigned m;
    int unsigned p;
    bin_word_t w;
    ring[ring_wr] = s;
    ring_wr = (ring_wr + 1) % WIN;
    hop_seen = (hop_seen + 1) & 8'h7f;
    if (hop_seen < hop_len) return;
    hop_seen = 0;
    for (int k = 0; k < BINS; k++) begin
      re = 0;
      im = 0;
      for (int t = 0; t < WIN; t++) begin
        x = ring[(ring_wr + t) % WIN];
        m = (t * k) % WIN;
        p = ((m * 128 + WIN / 2) / WIN) & 127;
        re += x * quarter_sine_q14((p + 32) & 127);
        im -= x * quarter_sine_q14(p);
      end
      a = round_mag_q14(re);
      b = round_mag_q14(im);
      mag = int_sqrt(a * a + b * b);
      if (mag > 64'd4194303) mag = 64'd4194303;
      w.bin_index = k[swdm_pkg::BIN_W-1:0];
      w.magnitude = mag[swdm_pkg::MAG_W-1:0];
      w.last_bin  = (k == BINS - 1);
      expected_bins.push_back(w);
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: bursts of words with random gaps; prediction on acceptance.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_spectrum(sample_i);
        void'(pending_samples.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (driver_paused || pending_samples.size() == 0 ||
                     (in_valid_i && in_ready_o && pending_samples.size() == 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          sample_i <= pending_samples[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
          end
        end
      end
    end
  end

  // Hold-off counter runs in its own process.
  always @(posedge clk_i) begin
    if (hold_off_req && hold_off_left == 0) begin
      hold_off_left <= 3 * SPECTRUM_CYCLES;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Monitor: stall pattern on ready, compare each accepted word in order.
  int stall_phase = 0;
  always @(posedge clk_i) begin
    bin_word_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bins.size() == 0) begin
          report_mismatch("unexpected word, bin", bin_index_o, -1);
        end else begin
          want = expected_bins.pop_front();
          if (bin_index_o !== want.bin_index)
            report_mismatch("bin_index", bin_index_o, want.bin_index);
          if (magnitude_o !== want.magnitude)
            report_mismatch("magnitude", magnitude_o, want.magnitude);
          if (last_bin_o !== want.last_bin)
            report_mismatch("last_bin", last_bin_o, want.last_bin);
        end
      end
      stall_phase = (stall_phase + 1) % 40;
      if (hold_off_left > 0 || (hold_off_req && hold_off_left == 0)) begin
        out_ready_i <= 1'b0;
      end else if (stall_phase < 20) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (SPECTRUM_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_hop(logic [swdm_pkg::HOP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    hop_len = value;
  endtask

  function automatic logic signed [swdm_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return swdm_pkg::SAMPLE_W'($urandom_range(0, 15));
      default: return swdm_pkg::SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    logic [swdm_pkg::HOP_W-1:0] hops[6];
    for (int i = 0; i < WIN; i++) ring[i] = '0;
    ring_wr = 0;
    hop_seen = 0;
    hop_len = swdm_pkg::HOP_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, alternating sign, under the reset hop length
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sh0000);
    pending_samples.push_back(-16'sd1);
    pending_samples.push_back(16'sd1);
    for (int i = 0; i < 11; i++) pending_samples.push_back(i[0] ? 16'sh8000 : 16'sh7fff);
    wait_drained();

    // hop length zero behaves like one
    write_hop(7'd0);
    pending_samples.push_back(16'sh5555);
    pending_samples.push_back(16'shaaaa);
    wait_drained();

    // long output hold-off while the sender keeps offering
    write_hop(7'd1);
    hold_off_req = 1'b1;
    for (int i = 0; i < 6; i++) pending_samples.push_back(rand_sample());
    @(posedge clk_i);
    while (hold_off_left == 0) @(posedge clk_i);
    hold_off_req = 1'b0;
    wait_drained();

    // random phases across hop settings, extremes included
    hops = '{7'd127, 7'd64, 7'd9, 7'd33, 7'd1, 7'd16};
    foreach (hops[h]) begin
      write_hop(hops[h]);
      for (int i = 0; i < 70; i++) pending_samples.push_back(rand_sample());
      // sender pauses until all due bins are back
      while (pending_samples.size() > 35) @(posedge clk_i);
      driver_paused = 1'b1;
      while (in_valid_i) @(posedge clk_i);
      while (expected_bins.size() != 0) @(posedge clk_i);
      driver_paused = 1'b0;
      wait_drained();
    end

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
